@@ rtl/core/apbv_pkg.sv @@
// Shared types, constants and helper functions for the address/payload block validator.
// Used by address_payload_block_validator; has no dependencies of its own.

package apbv_pkg;

	// Command store geometry.
	localparam int CMD_DEPTH = 32;
	localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_LW    = $clog2(CMD_DEPTH + 1);

	// Decimal forms of the address registers.
	localparam int NET_DIGITS = 10;
	localparam int DEV_DIGITS = 5;
	localparam int BCD_W      = 4 * NET_DIGITS;
	localparam int DEV_BCD_W  = 4 * DEV_DIGITS;
	localparam int CONV_W     = 32;
	localparam int CONV_CW    = $clog2(CONV_W);

	// Widths of the parse state.
	localparam int FLD_W   = 4;
	localparam int POS_W   = 7;
	localparam int ACC_W   = 17;
	localparam int SAVED_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;
	localparam logic [FLD_W-1:0] FLD_MAX = '1;

	// Field numbers inside a message.
	localparam logic [FLD_W-1:0] FLD_NONE  = 4'd0;
	localparam logic [FLD_W-1:0] FLD_FIRST = 4'd1;
	localparam logic [FLD_W-1:0] FLD_NUM   = 4'd2;
	localparam logic [FLD_W-1:0] FLD_TYPE  = 4'd3;
	localparam logic [FLD_W-1:0] FLD_NET   = 4'd4;
	localparam logic [FLD_W-1:0] FLD_DEV   = 4'd5;

	// Characters of interest.
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_P    = 8'h50;

	typedef enum logic [1:0] {
		BT_EMPTY = 2'd0,
		BT_ADDR  = 2'd1,
		BT_PAY   = 2'd2,
		BT_OTHER = 2'd3
	} btype_t;

	typedef enum logic [1:0] {
		STAT_REJECT  = 2'd0,
		STAT_ADDR_OK = 2'd1,
		STAT_PAY_OK  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NET = 1'b0,
		REG_DEV = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_RUN,
		S_CONV,
		S_FINISH,
		S_READ,
		S_SEND
	} fsm_t;

	// Number of significant decimal digits in a BCD word, at least one.
	function automatic logic [3:0] dec_count(input logic [BCD_W-1:0] bcd);
		logic [3:0] n;
		n = 4'd1;
		for (int i = 1; i < NET_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

	// ASCII character of BCD digit number idx (0 is the least significant).
	function automatic logic [7:0] dec_char(input logic [BCD_W-1:0] bcd,
	                                        input logic [3:0] idx);
		logic [3:0] d;
		d = bcd[{idx, 2'b00} +: 4];
		return {CH_ZERO[7:4], d};
	endfunction

endpackage

@@ rtl/core/apbv_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced by the validator for its command store.

module apbv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, and a read port whose data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/address_payload_block_validator.sv @@
// Address/payload block validator: parses '#'-separated message text byte by byte.
// Depends on apbv_pkg and on apbv_ram for the command store.
//
// Usage: message bytes enter on the in channel (rx_byte, end_of_message), one
// transaction per byte; the byte with end_of_message set closes the message.
// Results leave on the out channel (status, cmd_char, char_valid, last) only
// after the final byte: one for a rejected block, an address block or a payload
// block with no commands, or one per command character, with last on the final one.
// Throughput: one byte per cycle while a message is parsed and no configuration
// write waits. After the final byte the verdict is formed, and each command
// character is read from the command RAM before it is sent. The input stays
// stalled until the last result is in the output register. Configuration writes
// (index 0 network address, index 1 device address) are to be taken between
// messages; the block does not enforce this. Each starts a binary-to-decimal
// conversion, during which neither channel accepts. When the receiver stalls,
// the result holds in the output register and the block waits. Reset clears all
// message state, the saved block number and both addresses (decimal "0").

module address_payload_block_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          rx_byte,
	input  logic                                end_of_message,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [7:0]                          cmd_char,
	output logic                                char_valid,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [apbv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apbv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	apbv_pkg::fsm_t state_q, state_n;

	// Per-message parse state.
	logic [apbv_pkg::FLD_W-1:0]   fn_q, fn_n, fn_inc;
	logic [apbv_pkg::POS_W-1:0]   pos_q, pos_n;
	logic                         text_end_q, text_end_n;
	logic                         hash_q, hash_n;
	apbv_pkg::btype_t             btype_q, btype_n;
	logic [apbv_pkg::ACC_W-1:0]   acc_q, acc_n;
	logic [20:0]                  acc_mul;
	logic                         dstop_q, dstop_n;
	logic                         netm_q, netm_n;
	logic                         devm_q, devm_n;
	logic [apbv_pkg::CMD_LW-1:0]  len_q, len_n;
	logic                         wr_en;

	// Kept across messages.
	logic [apbv_pkg::SAVED_W-1:0] saved_q;
	logic [apbv_pkg::BCD_W-1:0]   net_bcd_q;
	logic [3:0]                   net_ndig_q;
	logic [apbv_pkg::DEV_BCD_W-1:0] dev_bcd_q;
	logic [2:0]                   dev_ndig_q;

	// Decimal converter.
	logic [apbv_pkg::CONV_W-1:0]  conv_bin_q;
	logic [apbv_pkg::BCD_W-1:0]   conv_bcd_q, conv_adj, conv_bcd_nxt;
	logic [apbv_pkg::CONV_CW-1:0] conv_cnt_q;
	apbv_pkg::reg_idx_t           conv_sel_q;
	logic [3:0]                   conv_ndig;
	logic                         conv_done;

	// Command readout and output register.
	logic [apbv_pkg::CMD_AW-1:0]  rd_idx_q;
	logic                         rd_last;
	logic                         ram_re;
	logic [7:0]                   ram_rdata;
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [7:0]                   cmd_char_q;
	logic                         char_valid_q;
	logic                         last_q;
	logic                         out_free;
	logic                         ld_out;
	logic [1:0]                   out_status_n;
	logic [7:0]                   out_char_n;
	logic                         out_cv_n;
	logic                         out_last_n;
	logic                         clr_msg;
	logic                         rd_start;
	logic                         rd_step;

	// Verdict terms.
	logic                         net_dig_ok, dev_dig_ok;
	logic                         netm_fin, devm_fin;
	logic                         v_bad_start, v_addr, v_pay;
	logic                         fin_take;
	logic                         in_fire, cfg_fire;

	assign cfg_ready = (state_q == apbv_pkg::S_RUN);
	assign in_ready  = (state_q == apbv_pkg::S_RUN) && !cfg_valid;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Double-dabble step: add three to digits of five or more, then shift.
	always_comb begin
		for (int i = 0; i < apbv_pkg::NET_DIGITS; i++) begin
			conv_adj[4*i +: 4] = (conv_bcd_q[4*i +: 4] >= 4'd5) ?
				conv_bcd_q[4*i +: 4] + 4'd3 : conv_bcd_q[4*i +: 4];
		end
		conv_bcd_nxt = {conv_adj[apbv_pkg::BCD_W-2:0], conv_bin_q[apbv_pkg::CONV_W-1]};
		conv_ndig    = apbv_pkg::dec_count(conv_bcd_nxt);
	end

	assign conv_done = (state_q == apbv_pkg::S_CONV) && (conv_cnt_q == '1);

	// Digit checks of the address fields at the current position.
	assign net_dig_ok = (pos_q < {3'b000, net_ndig_q}) &&
		(rx_byte == apbv_pkg::dec_char(net_bcd_q, net_ndig_q - 4'd1 - pos_q[3:0]));
	assign dev_dig_ok = (pos_q < {4'b0000, dev_ndig_q}) &&
		(rx_byte == apbv_pkg::dec_char({{(apbv_pkg::BCD_W-apbv_pkg::DEV_BCD_W){1'b0}},
			dev_bcd_q}, {1'b0, dev_ndig_q} - 4'd1 - pos_q[3:0]));

	assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, rx_byte[3:0]};
	assign fn_inc  = (fn_q != apbv_pkg::FLD_MAX) ? fn_q + 4'd1 : fn_q;

	// Next parse state for one received byte.
	always_comb begin
		fn_n       = fn_q;
		pos_n      = pos_q;
		text_end_n = text_end_q;
		hash_n     = hash_q;
		btype_n    = btype_q;
		acc_n      = acc_q;
		dstop_n    = dstop_q;
		netm_n     = netm_q;
		devm_n     = devm_q;
		len_n      = len_q;
		wr_en      = 1'b0;
		if (!text_end_q) begin
			if (rx_byte == apbv_pkg::CH_NUL) begin
				text_end_n = 1'b1;
			end else if (fn_q == apbv_pkg::FLD_NONE) begin
				hash_n = (rx_byte == apbv_pkg::CH_HASH);
				fn_n   = (rx_byte == apbv_pkg::CH_HASH) ? apbv_pkg::FLD_NUM : apbv_pkg::FLD_FIRST;
				pos_n  = '0;
			end else if (rx_byte == apbv_pkg::CH_HASH) begin
				if (fn_q == apbv_pkg::FLD_NET) begin
					netm_n = netm_q && (pos_q == {3'b000, net_ndig_q});
				end
				if (fn_q == apbv_pkg::FLD_DEV) begin
					devm_n = devm_q && (pos_q == {4'b0000, dev_ndig_q});
				end
				fn_n  = fn_inc;
				pos_n = '0;
				if (fn_inc == apbv_pkg::FLD_NET) begin
					netm_n = 1'b1;
				end else if (fn_inc == apbv_pkg::FLD_DEV) begin
					devm_n = 1'b1;
				end
			end else begin
				case (fn_q)
					apbv_pkg::FLD_NUM: begin
						if (!dstop_q && rx_byte >= apbv_pkg::CH_ZERO &&
						    rx_byte <= apbv_pkg::CH_NINE) begin
							acc_n = (acc_mul > {4'b0000, apbv_pkg::ACC_MAX}) ?
								apbv_pkg::ACC_MAX : acc_mul[apbv_pkg::ACC_W-1:0];
						end else begin
							dstop_n = 1'b1;
						end
					end
					apbv_pkg::FLD_TYPE: begin
						if (pos_q != '0) begin
							btype_n = apbv_pkg::BT_OTHER;
						end else if (rx_byte == apbv_pkg::CH_A) begin
							btype_n = apbv_pkg::BT_ADDR;
						end else if (rx_byte == apbv_pkg::CH_P) begin
							btype_n = apbv_pkg::BT_PAY;
						end else begin
							btype_n = apbv_pkg::BT_OTHER;
						end
					end
					apbv_pkg::FLD_NET: begin
						if (!net_dig_ok) begin
							netm_n = 1'b0;
						end
						if (len_q < apbv_pkg::CMD_LW'(apbv_pkg::CMD_DEPTH)) begin
							wr_en = 1'b1;
							len_n = len_q + 1'b1;
						end
					end
					apbv_pkg::FLD_DEV: begin
						if (!dev_dig_ok) begin
							devm_n = 1'b0;
						end
					end
					default: begin
					end
				endcase
				if (pos_q != apbv_pkg::POS_MAX) begin
					pos_n = pos_q + 1'b1;
				end
			end
		end
	end

	// Verdict at message end, with the open field closed.
	assign netm_fin = netm_q && ((fn_q != apbv_pkg::FLD_NET) || (pos_q == {3'b000, net_ndig_q}));
	assign devm_fin = devm_q && ((fn_q != apbv_pkg::FLD_DEV) ||
		(pos_q == {4'b0000, dev_ndig_q}));
	assign v_bad_start = (fn_q == apbv_pkg::FLD_NONE) || !hash_q;
	assign v_addr = (btype_q == apbv_pkg::BT_ADDR) && (fn_q >= apbv_pkg::FLD_DEV) &&
		netm_fin && devm_fin;
	assign v_pay  = (btype_q == apbv_pkg::BT_PAY) && (acc_q == {1'b0, saved_q} + 17'd1);
	assign rd_last = ({1'b0, rd_idx_q} + 1'b1) == len_q;

	// Next state and control strobes.
	always_comb begin
		state_n      = state_q;
		ld_out       = 1'b0;
		out_status_n = apbv_pkg::STAT_REJECT;
		out_char_n   = apbv_pkg::CH_NUL;
		out_cv_n     = 1'b0;
		out_last_n   = 1'b1;
		clr_msg      = 1'b0;
		ram_re       = 1'b0;
		rd_start     = 1'b0;
		rd_step      = 1'b0;
		fin_take     = 1'b0;
		case (state_q)
			apbv_pkg::S_RUN: begin
				if (cfg_fire) begin
					state_n = apbv_pkg::S_CONV;
				end else if (in_fire && end_of_message) begin
					state_n = apbv_pkg::S_FINISH;
				end
			end
			apbv_pkg::S_CONV: begin
				if (conv_done) begin
					state_n = apbv_pkg::S_RUN;
				end
			end
			apbv_pkg::S_FINISH: begin
				if (!v_bad_start && !v_addr && v_pay && len_q != '0) begin
					fin_take = 1'b1;
					rd_start = 1'b1;
					state_n  = apbv_pkg::S_READ;
				end else if (out_free) begin
					fin_take = 1'b1;
					ld_out   = 1'b1;
					clr_msg  = 1'b1;
					state_n  = apbv_pkg::S_RUN;
					if (!v_bad_start && v_addr) begin
						out_status_n = apbv_pkg::STAT_ADDR_OK;
					end else if (!v_bad_start && v_pay) begin
						out_status_n = apbv_pkg::STAT_PAY_OK;
					end
				end
			end
			apbv_pkg::S_READ: begin
				ram_re  = 1'b1;
				state_n = apbv_pkg::S_SEND;
			end
			apbv_pkg::S_SEND: begin
				if (out_free) begin
					ld_out       = 1'b1;
					out_status_n = apbv_pkg::STAT_PAY_OK;
					out_char_n   = ram_rdata;
					out_cv_n     = 1'b1;
					out_last_n   = rd_last;
					if (rd_last) begin
						clr_msg = 1'b1;
						state_n = apbv_pkg::S_RUN;
					end else begin
						rd_step = 1'b1;
						state_n = apbv_pkg::S_READ;
					end
				end
			end
			default: begin
				state_n = apbv_pkg::S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apbv_pkg::S_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	// Per-message registers: cleared after each verdict, updated per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q       <= apbv_pkg::FLD_NONE;
			pos_q      <= '0;
			text_end_q <= 1'b0;
			hash_q     <= 1'b0;
			btype_q    <= apbv_pkg::BT_EMPTY;
			acc_q      <= '0;
			dstop_q    <= 1'b0;
			netm_q     <= 1'b0;
			devm_q     <= 1'b0;
			len_q      <= '0;
		end else if (clr_msg) begin
			fn_q       <= apbv_pkg::FLD_NONE;
			pos_q      <= '0;
			text_end_q <= 1'b0;
			hash_q     <= 1'b0;
			btype_q    <= apbv_pkg::BT_EMPTY;
			acc_q      <= '0;
			dstop_q    <= 1'b0;
			netm_q     <= 1'b0;
			devm_q     <= 1'b0;
			len_q      <= '0;
		end else if (in_fire) begin
			fn_q       <= fn_n;
			pos_q      <= pos_n;
			text_end_q <= text_end_n;
			hash_q     <= hash_n;
			btype_q    <= btype_n;
			acc_q      <= acc_n;
			dstop_q    <= dstop_n;
			netm_q     <= netm_n;
			devm_q     <= devm_n;
			len_q      <= len_n;
		end
	end

	// Saved block number, decimal address forms, readout index and converter control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q    <= '0;
			net_bcd_q  <= '0;
			net_ndig_q <= 4'd1;
			dev_bcd_q  <= '0;
			dev_ndig_q <= 3'd1;
			rd_idx_q   <= '0;
			conv_cnt_q <= '0;
			conv_sel_q <= apbv_pkg::REG_NET;
		end else begin
			if (fin_take) begin
				if (!v_bad_start) begin
					if (v_addr) begin
						saved_q <= (acc_q[apbv_pkg::ACC_W-1] != 1'b0) ?
							'1 : acc_q[apbv_pkg::SAVED_W-1:0];
					end else begin
						saved_q <= '0;
					end
				end
			end
			if (rd_start) begin
				rd_idx_q <= '0;
			end else if (rd_step) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cfg_fire) begin
				conv_cnt_q <= '0;
				conv_sel_q <= apbv_pkg::reg_idx_t'(cfg_index);
			end else if (state_q == apbv_pkg::S_CONV) begin
				conv_cnt_q <= conv_cnt_q + 1'b1;
			end
			if (conv_done) begin
				if (conv_sel_q == apbv_pkg::REG_NET) begin
					net_bcd_q  <= conv_bcd_nxt;
					net_ndig_q <= conv_ndig;
				end else begin
					dev_bcd_q  <= conv_bcd_nxt[apbv_pkg::DEV_BCD_W-1:0];
					dev_ndig_q <= conv_ndig[2:0];
				end
			end
		end
	end

	// Converter shift registers.
	always_ff @(posedge clk) begin
		if (cfg_fire) begin
			conv_bcd_q <= '0;
			if (cfg_index == apbv_pkg::REG_DEV) begin
				conv_bin_q <= {16'd0, cfg_data[15:0]};
			end else begin
				conv_bin_q <= cfg_data;
			end
		end else if (state_q == apbv_pkg::S_CONV) begin
			conv_bcd_q <= conv_bcd_nxt;
			conv_bin_q <= {conv_bin_q[apbv_pkg::CONV_W-2:0], 1'b0};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			status_q     <= out_status_n;
			cmd_char_q   <= out_char_n;
			char_valid_q <= out_cv_n;
			last_q       <= out_last_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign cmd_char   = cmd_char_q;
	assign char_valid = char_valid_q;
	assign last       = last_q;

	// Command store.
	apbv_ram #(
		.WIDTH(8),
		.DEPTH(apbv_pkg::CMD_DEPTH)
	) u_cmd_ram (
		.clk   (clk),
		.we    (wr_en && in_fire),
		.waddr (len_q[apbv_pkg::CMD_AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	// The final byte of a message stalls the input until the verdict is out.
	a_eom_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_message |=> !in_ready)
		else $error("input accepted right after end of message");

	// Only payload results carry a command character.
	a_char_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> status == apbv_pkg::STAT_PAY_OK)
		else $error("command character outside a payload result");

	// A result without a command character is always the only one of its message.
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> last)
		else $error("single result without last");

	// The command length never runs past the store.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= apbv_pkg::CMD_LW'(apbv_pkg::CMD_DEPTH))
		else $error("command length beyond store depth");
`endif

endmodule
